FILE: rtl/core/single_source_shortest_paths_assert.svh
// Assertion macros used by the port-level checker.
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define SSSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define SSSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/core/sssp_pkg.sv
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared constants and types of the shortest path block.
// ----------------------------------------------------------------------------
`default_nettype none
package sssp_pkg;
	localparam int MaxVertices = 64;
	localparam int MaxEdges = 1024;
	localparam int VW = $clog2(MaxVertices);
	localparam int EW = $clog2(MaxEdges);
	localparam logic [31:0] DistInf = 32'hFFFF_FFFF;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OpClear = 2'd0;
	localparam opcode_t OpAdd = 2'd1;
	localparam opcode_t OpSolve = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_SEL_RD, ST_SEL_CMP, ST_SCAN, ST_RELAX,
		ST_OUT_RD, ST_OUT_SHOW
	} state_t;

	// vertex record: distance, predecessor, has_pred, reached, settled
	typedef struct packed {
		logic [31:0] distance;
		logic [VW-1:0] pred;
		logic has_pred;
		logic reached;
		logic settled;
	} vrec_t;
endpackage
`default_nettype wire

FILE: rtl/core/single_source_shortest_paths.sv
// ----------------------------------------------------------------------------
// single_source_shortest_paths
// Dijkstra over a graph held in an edge memory and a vertex memory.
// ----------------------------------------------------------------------------
// channel   direction  content
// s_axis    in         opcode, edge_from, edge_to, edge_weight, source_vertex
// m_axis    out        one transaction per vertex of a solve, tlast on final
// cfg       in         vertex_count write
// Input is taken only while idle. A solve initialises every vertex, then per
// settled vertex runs a select pass over all vertices and a scan of the
// stored edges, then a last select pass that finds nothing, then shows
// one result per vertex; the vertex memory has a single read-modify-write
// port. Reset clears control state only and does not clear the memories.
// m_axis stalls hold the walk.
// ----------------------------------------------------------------------------
`default_nettype none
module single_source_shortest_paths (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [6:0] cfg_wdata,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// opcode[1:0], edge_from[7:2], edge_to[13:8], edge_weight[29:14],
	// source_vertex[35:30], zero fill to 40
	input wire logic [39:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// vertex[5:0], distance[37:6], predecessor[43:38], zero fill to 48
	output logic [47:0] m_axis_tdata,
	// reachable[0], has_predecessor[1], edges_dropped[2]
	output logic [2:0] m_axis_tuser,
	output logic m_axis_tlast
);
	import sssp_pkg::*;

	localparam int EdgeW = 2 * VW + 16;

	logic [6:0] vcount_q;
	logic [EW:0] ecount_q;
	logic dropped_q;
	logic [VW:0] n_eff;
	state_t state_q, state_d;

	opcode_t op;
	logic [VW-1:0] in_from, in_to, in_src;
	logic [15:0] in_w;
	assign op = s_axis_tdata[1:0];
	assign in_from = s_axis_tdata[7:2];
	assign in_to = s_axis_tdata[13:8];
	assign in_w = s_axis_tdata[29:14];
	assign in_src = s_axis_tdata[35:30];

	// clamp the vertex count to 1..MaxVertices
	always_comb begin
		priority if (vcount_q == '0) begin
			n_eff = (VW+1)'(1);
		end else if (vcount_q > 7'(MaxVertices)) begin
			n_eff = (VW+1)'(MaxVertices);
		end else begin
			n_eff = vcount_q[VW:0];
		end
	end

	// vertex memory, one port, registered read
	vrec_t vmem [MaxVertices];
	logic v_we;
	logic [VW-1:0] v_addr;
	vrec_t v_wdata, v_rdata;
	always_ff @(posedge clk) begin
		if (v_we) begin
			vmem[v_addr] <= v_wdata;
		end
		v_rdata <= vmem[v_addr];
	end

	// edge memory
	logic e_we;
	logic [EdgeW-1:0] e_rdata;
	logic [EW-1:0] e_raddr;
	sssp_edge_ram u_edge_ram (
		.clk(clk), .we(e_we), .waddr(ecount_q[EW-1:0]),
		.wdata({in_w, in_to, in_from}), .raddr(e_raddr), .rdata(e_rdata)
	);

	logic in_acc;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign e_we = in_acc && op == OpAdd && {1'b0, in_from} < n_eff && {1'b0, in_to} < n_eff
		&& ecount_q != (EW+1)'(MaxEdges);

	// walk registers
	logic [VW:0] vi_q;
	logic [EW:0] ei_q;
	logic [VW-1:0] src_q, u_q;
	logic [31:0] udist_q, best_q;
	logic found_q;
	logic [VW-1:0] e_tail, e_head;
	logic [15:0] e_w;
	logic [32:0] sum;
	logic [31:0] cand;
	assign e_tail = e_rdata[VW-1:0];
	assign e_head = e_rdata[2*VW-1:VW];
	assign e_w = e_rdata[EdgeW-1:2*VW];
	assign sum = {1'b0, udist_q} + {17'b0, e_w};
	assign cand = sum[32] ? DistInf : sum[31:0];
	assign e_raddr = ei_q[EW-1:0];

	logic last_v, edge_hit, sel_better, show_done;
	assign last_v = (vi_q + 1'b1 == n_eff);
	assign edge_hit = e_tail == u_q && {1'b0, e_head} < n_eff;
	assign sel_better = v_rdata.reached && !v_rdata.settled
		&& (!found_q || v_rdata.distance < best_q);
	assign show_done = m_axis_tvalid && m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && op == OpSolve) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				if (last_v) begin
					state_d = ST_SEL_RD;
				end
			end
			ST_SEL_RD: state_d = ST_SEL_CMP;
			ST_SEL_CMP: begin
				if (last_v) begin
					state_d = (found_q || sel_better) ? ST_SCAN : ST_OUT_RD;
				end else begin
					state_d = ST_SEL_RD;
				end
			end
			ST_SCAN: begin
				// ei_q already issued; rdata valid next cycle in RELAX
				state_d = (ei_q == ecount_q) ? ST_SEL_RD : ST_RELAX;
			end
			ST_RELAX: state_d = ST_SCAN;
			ST_OUT_RD: state_d = ST_OUT_SHOW;
			ST_OUT_SHOW: begin
				if (show_done) begin
					state_d = last_v ? ST_IDLE : ST_OUT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// relax uses a second phase: RELAX reads the head record, commit in SCAN
	logic pend_q;
	logic [VW-1:0] ph_q;
	logic [31:0] pc_q;
	// settle the chosen vertex in the first scan cycle, when no relax is pending
	logic settle_q;
	vrec_t sv_q;

	// memory port control
	always_comb begin
		v_we = 1'b0;
		v_addr = vi_q[VW-1:0];
		v_wdata = v_rdata;
		unique case (state_q)
			ST_INIT: begin
				v_we = 1'b1;
				v_wdata.distance = (vi_q[VW-1:0] == src_q) ? '0 : DistInf;
				v_wdata.pred = '0;
				v_wdata.has_pred = 1'b0;
				v_wdata.reached = (vi_q[VW-1:0] == src_q);
				v_wdata.settled = 1'b0;
			end
			ST_SCAN: begin
				if (settle_q) begin
					v_we = 1'b1;
					v_addr = u_q;
					v_wdata = sv_q;
					v_wdata.settled = 1'b1;
				end else begin
					v_addr = ph_q;
					if (pend_q && !v_rdata.settled
						&& (!v_rdata.reached || pc_q < v_rdata.distance)) begin
						v_we = 1'b1;
						v_wdata.distance = pc_q;
						v_wdata.pred = u_q;
						v_wdata.has_pred = 1'b1;
						v_wdata.reached = 1'b1;
					end
				end
			end
			ST_RELAX: v_addr = e_head;
			default: ;
		endcase
	end

	// walk sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vcount_q <= 7'(MaxVertices);
			ecount_q <= '0;
			dropped_q <= 1'b0;
			vi_q <= '0;
			ei_q <= '0;
			found_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			if (in_acc && op == OpClear) begin
				ecount_q <= '0;
				dropped_q <= 1'b0;
			end
			if (e_we) begin
				ecount_q <= ecount_q + 1'b1;
			end else if (in_acc && op == OpAdd && {1'b0, in_from} < n_eff
				&& {1'b0, in_to} < n_eff) begin
				dropped_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: vi_q <= '0;
				ST_INIT: begin
					vi_q <= last_v ? '0 : vi_q + 1'b1;
					found_q <= 1'b0;
				end
				ST_SEL_CMP: begin
					if (sel_better) begin
						found_q <= 1'b1;
					end
					vi_q <= last_v ? '0 : vi_q + 1'b1;
					pend_q <= 1'b0;
					ei_q <= '0;
				end
				ST_SCAN: begin
					pend_q <= 1'b0;
					if (ei_q == ecount_q) begin
						found_q <= 1'b0;
					end
				end
				ST_RELAX: begin
					pend_q <= edge_hit;
					ei_q <= ei_q + 1'b1;
				end
				ST_OUT_SHOW: begin
					if (show_done) begin
						vi_q <= vi_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			src_q <= in_src;
		end
		if (state_q == ST_SEL_CMP && sel_better) begin
			best_q <= v_rdata.distance;
			u_q <= vi_q[VW-1:0];
			sv_q <= v_rdata;
		end
		if (state_q == ST_RELAX) begin
			ph_q <= e_head;
			pc_q <= cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 1'b0;
		end else begin
			settle_q <= (state_q == ST_SEL_CMP && last_v && (found_q || sel_better));
		end
	end
	always_ff @(posedge clk) begin
		if (state_q == ST_SEL_CMP && last_v) begin
			udist_q <= sel_better ? v_rdata.distance : best_q;
		end
	end

	// output stage
	assign m_axis_tvalid = (state_q == ST_OUT_SHOW);
	assign m_axis_tdata = {4'b0, v_rdata.pred & {VW{v_rdata.has_pred}},
		v_rdata.distance, vi_q[VW-1:0]};
	assign m_axis_tuser = {dropped_q, v_rdata.has_pred, v_rdata.reached};
	assign m_axis_tlast = last_v;
endmodule
`default_nettype wire

FILE: rtl/core/sssp_edge_ram.sv
// ----------------------------------------------------------------------------
// sssp_edge_ram
// Edge store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module sssp_edge_ram (
	input wire logic clk,
	input wire logic we,
	input wire logic [sssp_pkg::EW-1:0] waddr,
	input wire logic [2*sssp_pkg::VW+15:0] wdata,
	input wire logic [sssp_pkg::EW-1:0] raddr,
	output logic [2*sssp_pkg::VW+15:0] rdata
);
	import sssp_pkg::*;
	logic [2*VW+15:0] mem [MaxEdges];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/sssp_checker.sv
// ----------------------------------------------------------------------------
// sssp_checker
// Port-level checks of the shortest path block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "single_source_shortest_paths_assert.svh"
module sssp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic m_axis_tlast,
	input wire logic [47:0] m_axis_tdata
);
	`SSSP_ASSERT_IMP(a_no_in_while_out, clk, arst_n, m_axis_tvalid, !s_axis_tready, "input open during output")
	`SSSP_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output dropped")
	`SSSP_ASSERT_NXT(a_last_ends, clk, arst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "no return to idle")
endmodule
bind single_source_shortest_paths sssp_checker u_chk (.*);
`default_nettype wire

FILE: sim/single_source_shortest_paths_checker.sv
// ----------------------------------------------------------------------------
// single_source_shortest_paths_checker
// Watches the config, input and result channels of the shortest path block,
// keeps its own copy of the edge store, runs Dijkstra on every accepted
// solve and compares each result transaction with the oldest expectation.
// ----------------------------------------------------------------------------
module single_source_shortest_paths_checker
	import sssp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [6:0] cfg_wdata,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [39:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser,
	input logic m_axis_tlast,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [5:0] vertex;
		logic [31:0] distance;
		logic reachable;
		logic [5:0] predecessor;
		logic has_predecessor;
		logic edges_dropped;
		logic last;
	} vertex_result_t;

	vertex_result_t path_results_q[$];

	logic [6:0] vertex_count_reg;
	logic [5:0] edge_tail[MaxEdges];
	logic [5:0] edge_head[MaxEdges];
	logic [15:0] edge_weight[MaxEdges];
	int unsigned edge_count;
	logic dropped;

	assign pending = path_results_q.size();

	function automatic int unsigned vertices_in_use();
		if (vertex_count_reg == 0)
			return 1;
		if (vertex_count_reg > MaxVertices)
			return MaxVertices;
		return vertex_count_reg;
	endfunction

	// Run Dijkstra from src over the stored edges and queue one result per vertex.
	task automatic predict_paths(input int unsigned n, input int unsigned src);
		logic [31:0] best_dist[MaxVertices];
		int unsigned pred[MaxVertices];
		bit settled[MaxVertices];
		bit reached[MaxVertices];
		int unsigned u;
		logic [32:0] sum;
		logic [31:0] cand;
		vertex_result_t r;
		for (int v = 0; v < MaxVertices; v++) begin
			best_dist[v] = DistInf;
			pred[v] = MaxVertices;
			settled[v] = 0;
			reached[v] = 0;
		end
		if (src < n) begin
			best_dist[src] = 0;
			reached[src] = 1;
			forever begin
				u = n;
				for (int v = 0; v < n; v++) begin
					if (!reached[v] || settled[v])
						continue;
					if (u == n || best_dist[v] < best_dist[u])
						u = v;
				end
				if (u == n)
					break;
				settled[u] = 1;
				for (int e = 0; e < edge_count; e++) begin
					if (edge_tail[e] != u || edge_tail[e] >= n || edge_head[e] >= n)
						continue;
					if (settled[edge_head[e]])
						continue;
					sum = {1'b0, best_dist[u]} + edge_weight[e];
					cand = sum[32] ? DistInf : sum[31:0];
					if (!reached[edge_head[e]] || cand < best_dist[edge_head[e]]) begin
						best_dist[edge_head[e]] = cand;
						pred[edge_head[e]] = u;
						reached[edge_head[e]] = 1;
					end
				end
			end
		end
		for (int v = 0; v < n; v++) begin
			r.vertex = v[5:0];
			r.distance = best_dist[v];
			r.reachable = reached[v];
			r.has_predecessor = pred[v] < MaxVertices;
			r.predecessor = r.has_predecessor ? pred[v][5:0] : 6'd0;
			r.edges_dropped = dropped;
			r.last = (v + 1 == n);
			path_results_q = {path_results_q, r};
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [1:0] op;
		logic [5:0] from, to, src;
		int unsigned n;
		vertex_result_t exp_r;
		if (!arst_n) begin
			vertex_count_reg = 7'(MaxVertices);
			edge_count = 0;
			dropped = 0;
			path_results_q.delete();
			errors = 0;
		end else begin
			// results first: an expectation queued this edge cannot be due yet
			if (m_axis_tvalid && m_axis_tready) begin
				if (path_results_q.size() == 0) begin
					$display("%0t unexpected result transaction: expected none actual %h",
						$time, m_axis_tdata);
					errors++;
				end else begin
					exp_r = path_results_q.pop_front();
					check_field("vertex", exp_r.vertex, m_axis_tdata[5:0]);
					check_field("distance", exp_r.distance, m_axis_tdata[37:6]);
					check_field("predecessor", exp_r.predecessor, m_axis_tdata[43:38]);
					check_field("fill", 0, m_axis_tdata[47:44]);
					check_field("reachable", exp_r.reachable, m_axis_tuser[0]);
					check_field("has_predecessor", exp_r.has_predecessor, m_axis_tuser[1]);
					check_field("edges_dropped", exp_r.edges_dropped, m_axis_tuser[2]);
					check_field("last", exp_r.last, m_axis_tlast);
				end
			end
			// an input transaction on the edge of a config write sees the old count
			if (s_axis_tvalid && s_axis_tready) begin
				op = s_axis_tdata[1:0];
				from = s_axis_tdata[7:2];
				to = s_axis_tdata[13:8];
				src = s_axis_tdata[35:30];
				n = vertices_in_use();
				if (op == OpClear) begin
					edge_count = 0;
					dropped = 0;
				end else if (op == OpAdd) begin
					if (from < n && to < n) begin
						if (edge_count >= MaxEdges) begin
							dropped = 1;
						end else begin
							edge_tail[edge_count] = from;
							edge_head[edge_count] = to;
							edge_weight[edge_count] = s_axis_tdata[29:14];
							edge_count++;
						end
					end
				end else if (op == OpSolve) begin
					predict_paths(n, src);
				end
			end
			if (cfg_we)
				vertex_count_reg = cfg_wdata;
		end
	end
endmodule

FILE: sim/single_source_shortest_paths_tb.sv
// ----------------------------------------------------------------------------
// single_source_shortest_paths_tb
// Loads graphs edge by edge, solves them from chosen sources under several
// vertex counts, and lets the checker compare every per-vertex result.
// ----------------------------------------------------------------------------
module single_source_shortest_paths_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sssp_pkg::*;

	localparam opcode_t OpUnused = 2'd3;
	localparam int IdleLimit = 600000;
	// let clear and add finish; leave margin before a config write
	localparam int SettleCycles = 20;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [6:0] cfg_wdata = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [47:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic m_axis_tlast;
	int errors;
	int pending;
	int idle_cycles = 0;
	bit send_burst = 0;
	bit recv_burst = 0;
	int unsigned n_now = MaxVertices;

	always #5 clk = ~clk;

	single_source_shortest_paths dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	single_source_shortest_paths_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast), .errors(errors), .pending(pending)
	);

	// Abort if no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: unless in a burst, stall for a random gap before taking each transaction.
	initial begin
		int gap;
		bit taken;
		@(posedge arst_n);
		forever begin
			gap = recv_burst ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1;
			// valid is stable from the falling edge up to the next rising edge
			do begin
				@(negedge clk);
				taken = m_axis_tvalid;
				@(posedge clk);
			end while (!taken);
		end
	end

	// Drive one input transaction, after a random gap unless in a burst; hold until accepted.
	task automatic send_item(input opcode_t op, input logic [5:0] from,
			input logic [5:0] to, input logic [15:0] weight, input logic [5:0] src);
		int gap;
		bit taken;
		gap = send_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {4'b0, src, weight, to, from, op};
		do begin
			@(negedge clk);
			taken = s_axis_tready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Drop valid, let all expected results drain, then wait SettleCycles.
	task automatic drain_results();
		s_axis_tvalid <= 0;
		do @(negedge clk); while (pending != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_vertex_count(input logic [6:0] value);
		drain_results();
		cfg_we <= 1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 0;
		n_now = value == 0 ? 1 : (value > MaxVertices ? MaxVertices : value);
	endtask

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	// Mostly in-range vertex; now and then one anywhere in the field.
	function automatic logic [5:0] pick_vertex();
		if ($urandom_range(0, 9) == 0)
			return 6'($urandom());
		return 6'($urandom_range(0, n_now - 1));
	endfunction

	initial begin
		int items;
		int k;
		logic [6:0] counts[7] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd17, 7'd3, 7'd40};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: improvement, ties, heavy edge, self loop, outside edges, bad sources.
		set_vertex_count(7'd6);
		send_item(OpClear, 0, 0, 0, 0);
		send_item(OpAdd, 0, 1, 16'd5, 0);
		send_item(OpAdd, 0, 2, 16'd1, 0);
		send_item(OpAdd, 2, 1, 16'd2, 0);
		send_item(OpAdd, 2, 1, 16'd2, 0);
		send_item(OpAdd, 0, 1, 16'd3, 0);
		send_item(OpAdd, 1, 3, 16'hFFFF, 0);
		send_item(OpAdd, 3, 3, 16'd0, 0);
		send_item(OpAdd, 3, 4, 16'd0, 0);
		send_item(OpAdd, 6'd63, 0, 16'd1, 0);
		send_item(OpAdd, 0, 6'd63, 16'd1, 0);
		send_item(OpUnused, 6'd63, 6'd63, 16'hFFFF, 6'd63);
		send_item(OpSolve, 0, 0, 0, 0);
		send_item(OpSolve, 0, 0, 0, 6'd5);
		send_item(OpSolve, 0, 0, 0, 6'd6);
		send_item(OpSolve, 6'd63, 6'd63, 16'hFFFF, 6'd63);
		// shrink the graph: edges reaching vertex 4 or 5 are now skipped
		set_vertex_count(7'd4);
		send_item(OpSolve, 0, 0, 0, 0);

		// Fill the edge store past capacity on a two-vertex graph.
		set_vertex_count(7'd2);
		send_burst = 1;
		send_item(OpClear, 0, 0, 0, 0);
		for (int e = 0; e < MaxEdges + 6; e++)
			send_item(OpAdd, 6'($urandom_range(0, 1)), 6'($urandom_range(0, 1)),
				16'($urandom()), 0);
		send_burst = 0;
		send_item(OpSolve, 0, 0, 0, 0);
		send_item(OpSolve, 0, 0, 0, 1);
		send_item(OpClear, 0, 0, 0, 0);
		send_item(OpSolve, 0, 0, 0, 1);

		// Random graphs under a series of vertex counts.
		items = 0;
		for (int phase = 0; items < 100; phase++) begin
			set_vertex_count(phase < 7 ? counts[phase] : 7'($urandom()));
			for (int s = 0; s < 3; s++) begin
				send_burst = $urandom_range(0, 3) == 0;
				recv_burst = $urandom_range(0, 3) == 0;
				if ($urandom_range(0, 4) != 0) begin
					if ($urandom_range(0, 3) != 0) begin
						send_item(OpClear, 6'($urandom()), 6'($urandom()), 16'($urandom()),
							6'($urandom()));
						items++;
					end
					k = $urandom_range(0, 12);
					for (int e = 0; e < k; e++) begin
						send_item(OpAdd, pick_vertex(), pick_vertex(), pick_weight(),
							6'($urandom()));
						items++;
					end
					send_item(OpSolve, 6'($urandom()), 6'($urandom()), 16'($urandom()),
						pick_vertex());
					items++;
				end else begin
					// noise: any opcode, any field
					k = $urandom_range(1, 4);
					for (int e = 0; e < k; e++) begin
						send_item(opcode_t'($urandom()), 6'($urandom()), 6'($urandom()),
							16'($urandom()), 6'($urandom()));
						items++;
					end
				end
			end
		end
		send_burst = 0;
		recv_burst = 0;

		drain_results();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
